>>> hw/rtl/tmrm_pkg.sv
// Package for the tile map column ray marcher.
// Holds map geometry, register indexes, outcome codes and shared types.
package tmrm_pkg;

   localparam int MAP_ROWS = 10;
   localparam int MAP_COLS = 10;
   localparam int MAP_BITS = 100;
   localparam int CELL_W   = 7;

   localparam logic [2:0] REG_MAP_LOW   = 3'd0;
   localparam logic [2:0] REG_MAP_HIGH  = 3'd1;
   localparam logic [2:0] REG_MAX_DEPTH = 3'd2;
   localparam logic [2:0] REG_TILE      = 3'd3;
   localparam logic [2:0] REG_PROJ      = 3'd4;
   localparam logic [2:0] REG_SCR_W     = 3'd5;
   localparam logic [2:0] REG_SCR_H     = 3'd6;
   localparam logic [2:0] REG_RAYS      = 3'd7;

   localparam logic [1:0] OUT_HIT   = 2'd0;
   localparam logic [1:0] OUT_LEFT  = 2'd1;
   localparam logic [1:0] OUT_DEPTH = 2'd2;

   // Command to the shared divider.
   typedef struct packed {
      logic        start;
      logic [47:0] num;
      logic [47:0] den;
   } div_cmd_type;

   // Status back from the shared divider.
   typedef struct packed {
      logic        done;
      logic [47:0] quo;
   } div_sts_type;

endpackage

>>> hw/rtl/tmrm_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on tmrm_pkg for the command and status structs.
module tmrm_div import tmrm_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_cmd_type cmd,
   output div_sts_type sts
);

   logic [47:0] quo_ff, quo_in;
   logic [48:0] rem_ff, rem_in;
   logic [47:0] den_ff, den_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [48:0] trial;

   // One shift and subtract step per cycle.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[47:0], quo_ff[47]};
      if (cmd.start) begin
         quo_in  = cmd.num;
         rem_in  = '0;
         den_in  = cmd.den;
         cnt_in  = 6'd48;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            quo_in = {quo_ff[46:0], 1'b1};
         end else begin
            rem_in = trial;
            quo_in = {quo_ff[46:0], 1'b0};
         end
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign sts.done = done_ff;
   assign sts.quo  = quo_ff;

   a_done_after_busy: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(busy_ff)) else $error("divider done without work");
   a_no_busy_done: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divider done while busy");
   a_cnt_zero_idle: assert property (@(posedge clock) disable iff (reset)
      !busy_ff && !cmd.start |=> !busy_ff) else $error("divider woke itself");

endmodule

>>> hw/rtl/tile_map_ray_march_column.sv
// Top level of the tile map column ray marcher: registers, sequencer, datapath.
// Depends on tmrm_pkg and instantiates the shared divider tmrm_div.
//
// Usage: the req_ channel carries one ray (position, Q2.14 cosine and sine,
// column index). The block takes a ray when idle and marches it through the
// step unit; each depth step first forms the point, then looks up
// its cell with a compare ladder against multiples of the tile size.
// A wall hit adds an integer square root and, unless the distance is zero,
// one division for the wall height; column x and column width take one
// division each. Every division runs on the shared 48-step restoring divider.
// One ray is worked at a time; req_stall is high from acceptance until the
// result has been transferred, and the next ray can be taken in the cycle
// after that.
// The result sits in an output register on the rsp_ channel until rsp_stall
// drops; it holds still while stalled.
// Reset returns the sequencer to idle, clears the result valid and loads the
// configuration registers with their reset values. Configuration is to be
// written on csr_ only while the block is idle; the block does not enforce it.
module tile_map_ray_march_column import tmrm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write,
   input  logic [2:0]         csr_index,
   input  logic [59:0]        csr_data,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_ray_cos,
   input  logic signed [15:0] req_ray_sin,
   input  logic [11:0]        req_column_index,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_outcome,
   output logic [15:0]        rsp_hit_distance,
   output logic [11:0]        rsp_column_x,
   output logic [12:0]        rsp_column_width,
   output logic signed [16:0] rsp_top_row,
   output logic signed [16:0] rsp_bottom_row
);

   typedef enum logic [3:0] {
      S_IDLE, S_POINT, S_CELL, S_SQRT, S_HDIV, S_HWAIT,
      S_XDIV, S_XWAIT, S_WDIV, S_WWAIT, S_OUT
   } state_type;

   // Configuration registers.
   logic [59:0] map_lo_ff;
   logic [39:0] map_hi_ff;
   logic [11:0] depth_limit_ff;
   logic [9:0]  tile_ff;
   logic [23:0] proj_ff;
   logic [12:0] scr_w_ff, scr_h_ff, rays_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         map_lo_ff      <= '0;
         map_hi_ff      <= '0;
         depth_limit_ff <= 12'd1000;
         tile_ff        <= 10'd100;
         proj_ff        <= 24'd228122;
         scr_w_ff       <= 13'd1024;
         scr_h_ff       <= 13'd768;
         rays_ff        <= 13'd400;
      end else if (csr_write) begin
         case (csr_index)
            REG_MAP_LOW:   map_lo_ff      <= csr_data;
            REG_MAP_HIGH:  map_hi_ff      <= csr_data[39:0];
            REG_MAX_DEPTH: depth_limit_ff <= csr_data[11:0];
            REG_TILE:      tile_ff        <= csr_data[9:0];
            REG_PROJ:      proj_ff        <= csr_data[23:0];
            REG_SCR_W:     scr_w_ff       <= csr_data[12:0];
            REG_SCR_H:     scr_h_ff       <= csr_data[12:0];
            REG_RAYS:      rays_ff        <= csr_data[12:0];
            default:       ;
         endcase
      end
   end

   logic [9:0]          tile_eff;
   logic [12:0]         rays_eff;
   logic [MAP_BITS-1:0] map_bits;
   assign tile_eff = (tile_ff == '0) ? 10'd1 : tile_ff;
   assign rays_eff = (rays_ff == '0) ? 13'd1 : rays_ff;
   assign map_bits = {map_hi_ff, map_lo_ff};

   // Sequencer and datapath registers.
   state_type          state_ff, state_in;
   logic signed [15:0] px_ff, py_ff, cs_ff, sn_ff;
   logic [11:0]        col_ff;
   logic [11:0]        depth_ff, depth_in;
   logic signed [31:0] accx_ff, accx_in, accy_ff, accy_in;
   logic signed [17:0] rx_ff, rx_in, ry_ff, ry_in;
   logic [35:0]        sq_n_ff, sq_n_in;
   logic [35:0]        sq_res_ff, sq_res_in;
   logic [4:0]         sq_cnt_ff, sq_cnt_in;
   logic [1:0]         oc_ff, oc_in;
   logic [15:0]        dist_ff, dist_in;
   logic [15:0]        h_ff, h_in;
   logic [11:0]        cx_ff, cx_in;
   logic [12:0]        cw_ff, cw_in;
   logic               rv_ff, rv_in;
   div_cmd_type        dcmd;
   div_sts_type        dsts;

   tmrm_div u_div (.clock(clock), .reset(reset), .cmd(dcmd), .sts(dsts));

   // Truncating divide by 16384 and cell lookup by a compare ladder against the tile.
   logic signed [31:0] nx, ny;
   logic signed [17:0] qx, qy;
   logic [17:0]        ax, ay, cellx, celly;
   logic signed [17:0] ddx, ddy;
   logic [35:0]        dsq;
   logic [CELL_W-1:0]  bidx;
   logic [35:0]        sq_trial;
   logic signed [17:0] tmp_top;
   logic signed [17:0] half_top;

   always_comb begin
      nx = accx_ff;
      ny = accy_ff;
      qx = nx[31] ? -18'(((-nx) >>> 14)) : 18'(nx >>> 14);
      qy = ny[31] ? -18'(((-ny) >>> 14)) : 18'(ny >>> 14);
      ax = rx_ff[17] ? 18'(-rx_ff) : 18'(rx_ff);
      ay = ry_ff[17] ? 18'(-ry_ff) : 18'(ry_ff);
      // Cells from a small compare ladder against multiples of the tile.
      cellx = 18'd11;
      celly = 18'd11;
      for (int k = 10; k >= 0; k--) begin
         if (ax < 18'(28'(k + 1) * 28'(tile_eff))) cellx = 18'(k);
         if (ay < 18'(28'(k + 1) * 28'(tile_eff))) celly = 18'(k);
      end
      ddx  = rx_ff - 18'(px_ff);
      ddy  = ry_ff - 18'(py_ff);
      dsq  = 36'(ddx) * 36'(ddx) + 36'(ddy) * 36'(ddy);
      bidx = CELL_W'(celly * 18'(MAP_COLS) + cellx);
      sq_trial = sq_res_ff + (36'd1 << {sq_cnt_ff, 1'b0});
      tmp_top  = 18'(scr_h_ff) - 18'(h_ff);
      half_top = tmp_top >>> 1;
   end

   always_comb begin
      state_in  = state_ff;
      depth_in  = depth_ff;
      accx_in   = accx_ff;
      accy_in   = accy_ff;
      rx_in     = rx_ff;
      ry_in     = ry_ff;
      sq_n_in   = sq_n_ff;
      sq_res_in = sq_res_ff;
      sq_cnt_in = sq_cnt_ff;
      oc_in     = oc_ff;
      dist_in   = dist_ff;
      h_in      = h_ff;
      cx_in     = cx_ff;
      cw_in     = cw_ff;
      rv_in     = rv_ff;
      dcmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               accx_in  = 32'(req_pos_x) <<< 14;
               accy_in  = 32'(req_pos_y) <<< 14;
               depth_in = '0;
               oc_in    = OUT_DEPTH;
               dist_in  = '0;
               h_in     = '0;
               state_in = (depth_limit_ff == '0) ? S_XDIV : S_POINT;
            end
         end
         S_POINT: begin
            rx_in    = qx;
            ry_in    = qy;
            accx_in  = accx_ff + 32'(cs_ff);
            accy_in  = accy_ff + 32'(sn_ff);
            state_in = S_CELL;
         end
         S_CELL: begin
            if (rx_ff[17] && ax >= 18'(tile_eff) || ry_ff[17] && ay >= 18'(tile_eff)
                || cellx >= 18'(MAP_COLS) || celly >= 18'(MAP_ROWS)) begin
               oc_in    = OUT_LEFT;
               state_in = S_XDIV;
            end else if (map_bits[bidx]) begin
               oc_in     = OUT_HIT;
               sq_n_in   = dsq;
               sq_res_in = '0;
               sq_cnt_in = 5'd17;
               state_in  = S_SQRT;
            end else if (depth_ff == depth_limit_ff - 12'd1) begin
               state_in = S_XDIV;
            end else begin
               depth_in = depth_ff + 12'd1;
               state_in = S_POINT;
            end
         end
         S_SQRT: begin
            // One result bit of the integer square root per cycle.
            if (sq_n_ff >= sq_trial) begin
               sq_n_in   = sq_n_ff - sq_trial;
               sq_res_in = (sq_res_ff >> 1) + (36'd1 << {sq_cnt_ff, 1'b0});
            end else begin
               sq_res_in = sq_res_ff >> 1;
            end
            sq_cnt_in = sq_cnt_ff - 5'd1;
            if (sq_cnt_ff == '0) state_in = S_HDIV;
         end
         S_HDIV: begin
            dist_in = sq_res_ff[15:0];
            if (sq_res_ff == '0) begin
               h_in     = 16'hFFFF;
               state_in = S_XDIV;
            end else begin
               dcmd.start = 1'b1;
               dcmd.num   = 48'(tile_eff) * 48'(proj_ff);
               dcmd.den   = 48'(sq_res_ff) << 8;
               state_in   = S_HWAIT;
            end
         end
         S_HWAIT: begin
            if (dsts.done) begin
               h_in     = (dsts.quo > 48'd65535) ? 16'hFFFF : dsts.quo[15:0];
               state_in = S_XDIV;
            end
         end
         S_XDIV: begin
            dcmd.start = 1'b1;
            dcmd.num   = 48'(col_ff) * 48'(scr_w_ff);
            dcmd.den   = 48'(rays_eff);
            state_in   = S_XWAIT;
         end
         S_XWAIT: begin
            if (dsts.done) begin
               cx_in    = dsts.quo[11:0];
               state_in = S_WDIV;
            end
         end
         S_WDIV: begin
            dcmd.start = 1'b1;
            dcmd.num   = 48'(scr_w_ff);
            dcmd.den   = 48'(rays_eff);
            state_in   = S_WWAIT;
         end
         S_WWAIT: begin
            if (dsts.done) begin
               cw_in    = (dsts.quo >= 48'd8191) ? 13'd8191 : 13'(dsts.quo) + 13'd1;
               rv_in    = 1'b1;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_stall) begin
               rv_in    = 1'b0;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      if (state_ff == S_IDLE && req_valid) begin
         px_ff  <= req_pos_x;
         py_ff  <= req_pos_y;
         cs_ff  <= req_ray_cos;
         sn_ff  <= req_ray_sin;
         col_ff <= req_column_index;
      end
      depth_ff  <= depth_in;
      accx_ff   <= accx_in;
      accy_ff   <= accy_in;
      rx_ff     <= rx_in;
      ry_ff     <= ry_in;
      sq_n_ff   <= sq_n_in;
      sq_res_ff <= sq_res_in;
      sq_cnt_ff <= sq_cnt_in;
      oc_ff     <= oc_in;
      dist_ff   <= dist_in;
      h_ff      <= h_in;
      cx_ff     <= cx_in;
      cw_ff     <= cw_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rv_ff;
   assign rsp_outcome      = oc_ff;
   assign rsp_hit_distance = dist_ff;
   assign rsp_column_x     = cx_ff;
   assign rsp_column_width = cw_ff;
   assign rsp_top_row      = (oc_ff == OUT_HIT) ? half_top[16:0] : '0;
   assign rsp_bottom_row   = (oc_ff == OUT_HIT) ? 17'(half_top + 18'(h_ff)) : '0;

   a_valid_in_out: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> state_ff == S_OUT) else $error("result valid outside output state");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rv_ff |-> req_stall) else $error("input open while result pending");
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rv_ff && oc_ff != OUT_HIT |-> dist_ff == '0) else $error("distance on miss");

endmodule
